// ===== hw/rtl/tpt_pkg.sv =====
// tpt_pkg: shared types, codes and default sizes for the page-table translator.
// No dependencies; imported by every module of the block.
package tpt_pkg;

  localparam int unsigned TPT_TLB_ENTRIES = 16;
  localparam int unsigned TPT_PAGE_COUNT  = 256;
  localparam int unsigned TPT_PAGE_BYTES  = 256;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned NFF_W   = 9;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SRC_W   = 2;

  typedef enum logic [SRC_W-1:0] {
    SRC_TLB   = 2'd0,
    SRC_PT    = 2'd1,
    SRC_FAULT = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  // one page-table word: mapping present and its frame
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pt_entry_t;

endpackage

// ===== hw/rtl/tlb_page_table_translator.sv =====
// tlb_page_table_translator: address translation through a FIFO TLB and a page table.
// Depends on tpt_pkg, tpt_tlb_cell and tpt_page_table.
//
//  channel  | dir | tdata (low bit up)                               | tuser
//  ---------+-----+--------------------------------------------------+--------------
//  s_axis   | in  | virt_addr[15:0]                                  | -
//  m_axis   | out | phys_addr, frame_index, tlb_hit_count,           | source[1:0]
//           |     | fault_count, lookup_count, pad (128 bits total)  |
//
// In each transfer the accept cycle launches the page-table read, the next cycle
// resolves the TLB compare against the registered read word, and the output register
// is loaded once the output is free.
// After reset the page table is swept clear; s_axis_tready stays low until the sweep is done.
// The output register holds a result while m_axis stalls; one further input transfer
// is taken meanwhile and waits in the resolve cycle until the output frees up.
module tlb_page_table_translator
  import tpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = TPT_TLB_ENTRIES,
  parameter int unsigned PAGE_COUNT  = TPT_PAGE_COUNT,
  parameter int unsigned PAGE_BYTES  = TPT_PAGE_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [15:0] virt_addr
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] phys_addr, [23:16] frame_index, [55:24] tlb_hit_count,
  // [87:56] fault_count, [119:88] lookup_count, [127:120] zero
  output logic [127:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] source
);

  localparam int unsigned OW  = $clog2(PAGE_BYTES);
  localparam int unsigned PCW = $clog2(PAGE_COUNT);

  // ---------------------------------------------------------------- control
  state_e state_q, state_d;
  logic   pt_busy;
  logic   in_xfer;
  logic   out_free;
  logic   finish;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (!pt_busy) state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_LOOK;
      ST_LOOK:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    finish        = 1'b0;
    unique case (state_q)
      ST_CLEAR: ;
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_LOOK:  finish = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- address split
  logic [ADDR_W-1:0] in_page_full;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] page_full;
  logic [PCW-1:0]    page;
  logic [ADDR_W-1:0] offset;

  assign in_page_full = s_axis_tdata >> OW;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      addr_q <= s_axis_tdata;
    end
  end

  assign page_full = addr_q >> OW;
  assign page      = page_full[PCW-1:0];  // page number modulo the table size
  assign offset    = addr_q & ADDR_W'(PAGE_BYTES - 1);

  // ---------------------------------------------------------------- page table
  pt_entry_t pt_rd;
  pt_entry_t pt_wr;
  logic      pt_wr_en;

  tpt_page_table #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_page_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_page_full[PCW-1:0]),
    .rd_data_o (pt_rd),
    .wr_en_i   (pt_wr_en),
    .wr_addr_i (page),
    .wr_data_i (pt_wr),
    .busy_o    (pt_busy)
  );

  // ---------------------------------------------------------------- TLB chain
  // New entries enter at cell 0 and age down the chain; the last cell drops off,
  // which is the oldest entry, matching FIFO replacement. A page enters only on a
  // TLB miss, so no two valid cells ever match the same page.
  logic                 tlb_shift;
  logic [FRAME_W-1:0]   ins_frame;
  logic                 chain_valid [TLB_ENTRIES+1];
  logic [PCW-1:0]       chain_page  [TLB_ENTRIES+1];
  logic [FRAME_W-1:0]   chain_frame [TLB_ENTRIES+1];
  logic [TLB_ENTRIES-1:0] cell_hit;
  logic [FRAME_W-1:0]   cell_frame  [TLB_ENTRIES];

  assign chain_valid[0] = 1'b1;
  assign chain_page[0]  = page;
  assign chain_frame[0] = ins_frame;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    tpt_tlb_cell #(
      .PAGE_W (PCW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .shift_i       (tlb_shift),
      .valid_i       (chain_valid[i]),
      .page_i        (chain_page[i]),
      .frame_i       (chain_frame[i]),
      .lookup_page_i (page),
      .valid_o       (chain_valid[i+1]),
      .page_o        (chain_page[i+1]),
      .frame_o       (chain_frame[i+1]),
      .hit_o         (cell_hit[i]),
      .hit_frame_o   (cell_frame[i])
    );
  end

  logic               tlb_hit;
  logic [FRAME_W-1:0] tlb_frame;

  always_comb begin
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_frame = tlb_frame | cell_frame[i];
    end
  end
  assign tlb_hit = |cell_hit;

  // ---------------------------------------------------------------- resolve
  logic [NFF_W-1:0]   nff_q, nff_d;
  logic [CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]   fault_cnt_q, fault_cnt_d;
  logic [CNT_W-1:0]   lookup_cnt_q, lookup_cnt_d;
  logic [FRAME_W-1:0] frame;
  src_e               src;
  logic [31:0]        phys_wide;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  always_comb begin
    nff_d        = nff_q;
    hit_cnt_d    = hit_cnt_q;
    fault_cnt_d  = fault_cnt_q;
    lookup_cnt_d = sat_inc(lookup_cnt_q);
    pt_wr_en     = 1'b0;
    tlb_shift    = 1'b0;
    priority if (tlb_hit) begin
      src       = SRC_TLB;
      frame     = tlb_frame;
      hit_cnt_d = sat_inc(hit_cnt_q);
    end else if (pt_rd.valid) begin
      src       = SRC_PT;
      frame     = pt_rd.frame;
      tlb_shift = finish;
    end else begin
      // page fault: hand out the next frame, the counter wraps and frames get reused
      src         = SRC_FAULT;
      frame       = nff_q[FRAME_W-1:0];
      nff_d       = nff_q + NFF_W'(1);
      fault_cnt_d = sat_inc(fault_cnt_q);
      pt_wr_en    = finish;
      tlb_shift   = finish;
    end
  end

  assign ins_frame   = frame;
  assign pt_wr.valid = 1'b1;
  assign pt_wr.frame = frame;
  assign phys_wide   = (32'(frame) << OW) | 32'(offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nff_q        <= '0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      lookup_cnt_q <= '0;
    end else if (finish) begin
      nff_q        <= nff_d;
      hit_cnt_q    <= hit_cnt_d;
      fault_cnt_q  <= fault_cnt_d;
      lookup_cnt_q <= lookup_cnt_d;
    end
  end

  // ---------------------------------------------------------------- output register
  logic               m_valid_q, m_valid_d;
  logic [ADDR_W-1:0]  o_phys_q;
  logic [FRAME_W-1:0] o_frame_q;
  src_e               o_src_q;
  logic [CNT_W-1:0]   o_hit_q, o_fault_q, o_lookup_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (finish) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      o_phys_q   <= phys_wide[ADDR_W-1:0];
      o_frame_q  <= frame;
      o_src_q    <= src;
      o_hit_q    <= hit_cnt_d;
      o_fault_q  <= fault_cnt_d;
      o_lookup_q <= lookup_cnt_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {8'd0, o_lookup_q, o_fault_q, o_hit_q, o_frame_q, o_phys_q};
  assign m_axis_tuser  = o_src_q;

endmodule

// ===== hw/rtl/tpt_tlb_cell.sv =====
// tpt_tlb_cell: one TLB entry of the shifting entry chain.
// Depends on tpt_pkg.
module tpt_tlb_cell
  import tpt_pkg::*;
#(
  parameter int unsigned PAGE_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               valid_i,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic [PAGE_W-1:0]  lookup_page_i,
  output logic               valid_o,
  output logic [PAGE_W-1:0]  page_o,
  output logic [FRAME_W-1:0] frame_o,
  output logic               hit_o,
  output logic [FRAME_W-1:0] hit_frame_o
);

  logic               valid_q;
  logic [PAGE_W-1:0]  page_q;
  logic [FRAME_W-1:0] frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      page_q  <= page_i;
      frame_q <= frame_i;
    end
  end

  assign valid_o     = valid_q;
  assign page_o      = page_q;
  assign frame_o     = frame_q;
  assign hit_o       = valid_q && (page_q == lookup_page_i);
  // masked so the chain can OR the frames together; at most one entry matches
  assign hit_frame_o = hit_o ? frame_q : '0;

endmodule

// ===== hw/rtl/tpt_page_table.sv =====
// tpt_page_table: page-table memory with registered read and post-reset clear sweep.
// Depends on tpt_pkg.
module tpt_page_table
  import tpt_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = TPT_PAGE_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_addr_i,
  output pt_entry_t                     rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_addr_i,
  input  pt_entry_t                     wr_data_i,
  output logic                          busy_o
);

  localparam int unsigned PCW = $clog2(PAGE_COUNT);

  pt_entry_t        mem [PAGE_COUNT];
  pt_entry_t        rd_q;
  logic             clr_q, clr_d;
  logic [PCW-1:0]   clr_addr_q, clr_addr_d;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + PCW'(1);
      if (clr_addr_q == PCW'(PAGE_COUNT - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_q;

endmodule
